@@ sv/lpc_pkg.sv @@
// ----------------------------------------------------------------------------
// lpc_pkg
// Types and fixed constants shared by the light-level PI controller files.
// ----------------------------------------------------------------------------
package lpc_pkg;

    // field widths
    localparam int SAMPLE_WIDTH   = 10;
    localparam int SETPOINT_WIDTH = 11;
    localparam int GAIN_WIDTH     = 16;
    localparam int LUX_WIDTH      = 19;
    localparam int DUTY_WIDTH     = 8;
    localparam int STATUS_WIDTH   = 2;

    // internal widths
    localparam int ERR_WIDTH      = 21;
    localparam int INTEG_WIDTH    = 32;
    localparam int BAND_WIDTH     = 16;
    localparam int LUX_SHIFT      = 6;
    localparam int FRAC_BITS      = 8;

    // configuration word
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 16;

    // band is one tenth of the setpoint, as 6554/65536
    localparam int BAND_NUM       = 6554;
    localparam int LUX_MAX        = 524287;
    localparam int DRIVE_MAX_Q8   = 65280;
    localparam int NEG_DRIVE      = 100;
    localparam int FULL_SCALE     = 255;

    localparam logic [DUTY_WIDTH-1:0] NEG_COMPARE = DUTY_WIDTH'(FULL_SCALE - NEG_DRIVE);

    localparam logic [STATUS_WIDTH-1:0] STATUS_IN_RANGE = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] STATUS_CLAMPED  = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] STATUS_NEGATIVE = 2'd2;

    // register reset values
    localparam logic [SETPOINT_WIDTH-1:0] SETPOINT_RESET = 11'd400;
    localparam logic [GAIN_WIDTH-1:0]     PROP_RESET     = 16'd1044;
    localparam logic [GAIN_WIDTH-1:0]     INTEG_RESET    = 16'd1068;
    localparam logic [GAIN_WIDTH-1:0]     SLOPE_RESET    = 16'd21923;
    localparam logic [GAIN_WIDTH-1:0]     OFFSET_RESET   = 16'd678;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_SETPOINT      = 3'd0,
        REG_PROP_GAIN     = 3'd1,
        REG_INTEGRAL_GAIN = 3'd2,
        REG_CAL_SLOPE     = 3'd3,
        REG_CAL_OFFSET    = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic [CFG_INDEX_WIDTH-1:0] reg_index;
        logic [CFG_DATA_WIDTH-1:0]  reg_data;
    } cfg_word_t;

    typedef struct packed {
        logic [SAMPLE_WIDTH-1:0] adc_sample;
    } sample_word_t;

    typedef struct packed {
        logic [DUTY_WIDTH-1:0]   duty_compare;
        logic [LUX_WIDTH-1:0]    lux_measured;
        logic [STATUS_WIDTH-1:0] drive_status;
    } result_word_t;

    typedef struct packed {
        logic [SETPOINT_WIDTH-1:0] setpoint_lux;
        logic [GAIN_WIDTH-1:0]     prop_gain;
        logic [GAIN_WIDTH-1:0]     integral_gain;
        logic [GAIN_WIDTH-1:0]     cal_slope;
        logic [GAIN_WIDTH-1:0]     cal_offset;
    } cfg_regs_t;

endpackage

@@ sv/lpc_stream_if.sv @@
// ----------------------------------------------------------------------------
// lpc_stream_if
// Valid/ready channel carrying one payload word per handshake.
// ----------------------------------------------------------------------------
interface lpc_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );

endinterface

@@ sv/lpc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// lpc_cfg_regs
// Configuration register bank, written through its own valid/ready channel.
// ----------------------------------------------------------------------------
module lpc_cfg_regs
    import lpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    lpc_stream_if.sink  cfg,
    output cfg_regs_t   regs
);

    cfg_regs_t regs_reg;
    cfg_regs_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (reg_index_t'(cfg.payload.reg_index))
                REG_SETPOINT:
                    regs_next.setpoint_lux  = cfg.payload.reg_data[SETPOINT_WIDTH-1:0];
                REG_PROP_GAIN:
                    regs_next.prop_gain     = cfg.payload.reg_data[GAIN_WIDTH-1:0];
                REG_INTEGRAL_GAIN:
                    regs_next.integral_gain = cfg.payload.reg_data[GAIN_WIDTH-1:0];
                REG_CAL_SLOPE:
                    regs_next.cal_slope     = cfg.payload.reg_data[GAIN_WIDTH-1:0];
                REG_CAL_OFFSET:
                    regs_next.cal_offset    = cfg.payload.reg_data[GAIN_WIDTH-1:0];
                default:
                    regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.setpoint_lux  <= SETPOINT_RESET;
            regs_reg.prop_gain     <= PROP_RESET;
            regs_reg.integral_gain <= INTEG_RESET;
            regs_reg.cal_slope     <= SLOPE_RESET;
            regs_reg.cal_offset    <= OFFSET_RESET;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

@@ sv/lpc_serial_mult.sv @@
// ----------------------------------------------------------------------------
// lpc_serial_mult
// Digit-serial multiplier: signed multiplicand times unsigned multiplier,
// one multiplier digit per cycle, low product digits shifted out as they settle.
// ----------------------------------------------------------------------------
module lpc_serial_mult #(
    parameter int A_WIDTH     = 21,
    parameter int B_WIDTH     = 16,
    parameter int DIGIT_WIDTH = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [A_WIDTH-1:0]         a,
    input  logic        [B_WIDTH-1:0]         b,
    output logic                              done,
    output logic signed [A_WIDTH+B_WIDTH-1:0] product
);

    localparam int NDIG = (B_WIDTH + DIGIT_WIDTH - 1) / DIGIT_WIDTH;
    localparam int BP   = NDIG * DIGIT_WIDTH;
    localparam int HW   = A_WIDTH + 1;
    localparam int TW   = A_WIDTH + DIGIT_WIDTH + 1;
    localparam int CW   = $clog2(NDIG + 1);

    logic signed [A_WIDTH-1:0] a_reg;
    logic        [BP-1:0]      b_reg;
    logic signed [HW-1:0]      hi_reg;
    logic        [BP-1:0]      lo_reg;
    logic        [CW-1:0]      cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;

    logic [DIGIT_WIDTH-1:0]    digit;
    logic signed [TW-1:0]      pp;
    logic signed [TW-1:0]      t;
    logic [HW+BP-1:0]          full;

    assign digit = b_reg[DIGIT_WIDTH-1:0];
    assign pp    = $signed({{(TW-A_WIDTH){a_reg[A_WIDTH-1]}}, a_reg})
                 * $signed({{(TW-DIGIT_WIDTH){1'b0}}, digit});
    assign t     = $signed({{DIGIT_WIDTH{hi_reg[HW-1]}}, hi_reg}) + pp;

    assign full    = {hi_reg, lo_reg};
    assign product = $signed(full[A_WIDTH+B_WIDTH-1:0]);
    assign done    = done_reg;

    // operand and product shift registers
    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            a_reg  <= a;
            b_reg  <= BP'(b);
            hi_reg <= '0;
            lo_reg <= '0;
        end
        else if (busy_reg)
        begin
            b_reg  <= b_reg >> DIGIT_WIDTH;
            hi_reg <= t[TW-1:DIGIT_WIDTH];
            lo_reg <= BP'({t[DIGIT_WIDTH-1:0], lo_reg} >> DIGIT_WIDTH);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                cnt_reg  <= CW'(NDIG);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("multiplier started while busy");

    a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg != '0)
        else $error("multiplier busy with empty digit count");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("multiplier done held longer than one cycle");

endmodule

@@ sv/lux_pi_controller_unit.sv @@
// ----------------------------------------------------------------------------
// lux_pi_controller_unit
// PI light-level controller with an integral reset band. Each sample word is
// calibrated to lux (Q11.8, saturated), compared with the setpoint, and turned
// into a PWM compare value with a status code. Each item takes two passes
// of the digit-serial multipliers, one for calibration and one for the
// proportional and integral terms in parallel. A finished result sits in an
// output register, so a new sample is taken while the result waits to be read.
// ----------------------------------------------------------------------------
module lux_pi_controller_unit
    import lpc_pkg::*;
#(
    parameter int DIGIT_WIDTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    lpc_stream_if.sink   cfg,
    lpc_stream_if.sink   sample,
    lpc_stream_if.source result
);

    localparam int LUX_A_W   = SAMPLE_WIDTH + 1;
    localparam int LUX_P_W   = LUX_A_W + GAIN_WIDTH;
    localparam int LUX_S_W   = LUX_P_W - LUX_SHIFT + 1;
    localparam int ERR_P_W   = ERR_WIDTH + GAIN_WIDTH;
    localparam int INT_P_W   = INTEG_WIDTH + GAIN_WIDTH;
    localparam int SUM_W     = INT_P_W + 1;
    localparam int BAND_P_W  = SETPOINT_WIDTH + 13;
    localparam int DRIVE_W   = SUM_W - 1 - FRAC_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LUX,
        S_ERR,
        S_INTEG,
        S_PI,
        S_FIN
    } state_t;

    cfg_regs_t regs;

    state_t       state_reg, state_next;
    logic         out_valid_reg, out_valid_next;
    result_word_t out_word_reg, out_word_next;

    logic [LUX_WIDTH-1:0]         lux_reg;
    logic signed [ERR_WIDTH-1:0]  err_reg;
    logic [BAND_WIDTH-1:0]        band_reg;
    logic signed [INTEG_WIDTH-1:0] integ_reg, integ_next;

    logic lux_start, pi_start;
    logic lux_done, err_done, int_done;
    logic signed [LUX_P_W-1:0] lux_prod;
    logic signed [ERR_P_W-1:0] err_prod;
    logic signed [INT_P_W-1:0] int_prod;

    logic [BAND_P_W-1:0]         band_prod;
    logic [LUX_S_W-1:0]          lux_sum;
    logic [LUX_WIDTH-1:0]        lux_sat;
    logic signed [ERR_WIDTH-1:0] err_next;
    logic signed [ERR_WIDTH-1:0] band_ext;
    logic                        out_of_band;
    logic signed [INTEG_WIDTH:0] integ_sum;
    logic signed [SUM_W-1:0]     pi_sum;
    logic [DRIVE_W-1:0]          drive;
    logic [GAIN_WIDTH-1:0]       drive_diff;
    result_word_t                fin_word;

    lpc_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    lpc_serial_mult #(
        .A_WIDTH     (LUX_A_W),
        .B_WIDTH     (GAIN_WIDTH),
        .DIGIT_WIDTH (DIGIT_WIDTH)
    ) u_lux_mult (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (lux_start),
        .a       ($signed({1'b0, sample.payload.adc_sample})),
        .b       (regs.cal_slope),
        .done    (lux_done),
        .product (lux_prod)
    );

    lpc_serial_mult #(
        .A_WIDTH     (ERR_WIDTH),
        .B_WIDTH     (GAIN_WIDTH),
        .DIGIT_WIDTH (DIGIT_WIDTH)
    ) u_prop_mult (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (pi_start),
        .a       (err_reg),
        .b       (regs.prop_gain),
        .done    (err_done),
        .product (err_prod)
    );

    lpc_serial_mult #(
        .A_WIDTH     (INTEG_WIDTH),
        .B_WIDTH     (GAIN_WIDTH),
        .DIGIT_WIDTH (DIGIT_WIDTH)
    ) u_integ_mult (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (pi_start),
        .a       (integ_next),
        .b       (regs.integral_gain),
        .done    (int_done),
        .product (int_prod)
    );

    assign sample.ready   = (state_reg == S_IDLE);
    assign result.valid   = out_valid_reg;
    assign result.payload = out_word_reg;

    // band = setpoint * 256 * 6554 / 65536
    assign band_prod = BAND_P_W'(regs.setpoint_lux) * BAND_P_W'(BAND_NUM);

    // calibration: drop six product bits, add offset, saturate to Q11.8
    assign lux_sum = LUX_S_W'(lux_prod[LUX_P_W-1:LUX_SHIFT]) + LUX_S_W'(regs.cal_offset);
    assign lux_sat = (lux_sum > LUX_S_W'(LUX_MAX)) ? LUX_WIDTH'(LUX_MAX)
                                                   : lux_sum[LUX_WIDTH-1:0];

    assign err_next = $signed({2'b00, regs.setpoint_lux, {FRAC_BITS{1'b0}}})
                    - $signed({2'b00, lux_reg});

    assign band_ext    = $signed({{(ERR_WIDTH-BAND_WIDTH){1'b0}}, band_reg});
    assign out_of_band = (err_reg > band_ext) || (err_reg < -band_ext);

    assign integ_sum = $signed({integ_reg[INTEG_WIDTH-1], integ_reg})
                     + $signed({{(INTEG_WIDTH+1-ERR_WIDTH){err_reg[ERR_WIDTH-1]}}, err_reg});

    always_comb
    begin
        if (out_of_band)
            integ_next = '0;
        else if (integ_sum[INTEG_WIDTH] != integ_sum[INTEG_WIDTH-1])
            // saturate at the signed 32-bit limits
            integ_next = integ_sum[INTEG_WIDTH]
                       ? $signed({1'b1, {(INTEG_WIDTH-1){1'b0}}})
                       : $signed({1'b0, {(INTEG_WIDTH-1){1'b1}}});
        else
            integ_next = integ_sum[INTEG_WIDTH-1:0];
    end

    // final drive, clamp and compare value
    assign pi_sum = $signed({{(SUM_W-ERR_P_W){err_prod[ERR_P_W-1]}}, err_prod})
                  + $signed({int_prod[INT_P_W-1], int_prod});
    assign drive      = pi_sum[SUM_W-2:FRAC_BITS];
    assign drive_diff = GAIN_WIDTH'(DRIVE_MAX_Q8) - drive[GAIN_WIDTH-1:0];

    always_comb
    begin
        fin_word.lux_measured = lux_reg;
        if (pi_sum[SUM_W-1])
        begin
            fin_word.duty_compare = NEG_COMPARE;
            fin_word.drive_status = STATUS_NEGATIVE;
        end
        else if (drive > DRIVE_W'(DRIVE_MAX_Q8))
        begin
            fin_word.duty_compare = '0;
            fin_word.drive_status = STATUS_CLAMPED;
        end
        else
        begin
            fin_word.duty_compare = drive_diff[GAIN_WIDTH-1:FRAC_BITS];
            fin_word.drive_status = STATUS_IN_RANGE;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        lux_start      = 1'b0;
        pi_start       = 1'b0;
        if (result.ready)
            out_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (sample.valid)
                begin
                    lux_start  = 1'b1;
                    state_next = S_LUX;
                end
            end
            S_LUX:
            begin
                if (lux_done)
                    state_next = S_ERR;
            end
            S_ERR:
                state_next = S_INTEG;
            S_INTEG:
            begin
                pi_start   = 1'b1;
                state_next = S_PI;
            end
            S_PI:
            begin
                if (err_done)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                // hold the result until the output register is free
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = fin_word;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            out_word_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            out_word_reg  <= out_word_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            integ_reg <= '0;
        else if (state_reg == S_INTEG)
            integ_reg <= integ_next;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_LUX)
            band_reg <= band_prod[BAND_P_W-1:FRAC_BITS];
        if (lux_done)
            lux_reg <= lux_sat;
        if (state_reg == S_ERR)
            err_reg <= err_next;
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (sample.valid && sample.ready) |=> state_reg == S_LUX)
        else $error("accepted sample did not start calibration");

    a_lux_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        lux_done |-> state_reg == S_LUX)
        else $error("calibration product finished outside its phase");

    a_pi_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        err_done == int_done)
        else $error("proportional and integral lanes out of step");

    a_clamp_duty: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.payload.drive_status == STATUS_CLAMPED)
            |-> result.payload.duty_compare == '0)
        else $error("clamped drive with nonzero compare value");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.payload.drive_status == STATUS_IN_RANGE
                       || result.payload.drive_status == STATUS_CLAMPED
                       || result.payload.drive_status == STATUS_NEGATIVE))
        else $error("undefined drive status code");

endmodule
